FILE: src/box3_pkg.sv
// Shared constants, types and the divisor reciprocal table for the 3x3 box mean filter.
package box3_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 5;
    localparam int ROWS_CFG_W = 11;
    localparam int COLS_CFG_W = 6;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_COLS   = 32;
    localparam int MAX_ROWS   = 1024;

    // Column counter that can also hold the line length itself
    localparam int FX_W = COLS_CFG_W;

    // Neighbourhood sum and divisor widths
    localparam int CSUM_W  = PIX_W + 1;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 4;
    localparam int RECIP_W = 17;
    localparam int RECIP_SH = 16;
    localparam int PROD_W  = SUM_W + RECIP_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic accept;     // input transaction taken, start line buffer read
        logic load;       // shift window, update line buffers and position
        logic issue_a;    // window result left of the current column
        logic issue_b;    // window result at the current (last) column
        logic fl_read;    // flush: read line buffers at the sweep column
        logic fl_shift;   // flush: capture column sum into the sliding sums
        logic fl_phantom; // flush: shift in an empty column past the row end
        logic fl_issue;   // flush: hand one final row result to the divider
    } cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic emit_a;
        logic emit_b;
        logic flush;
        logic fx_end;
        logic fx_ready;
        logic fj_last;
    } stat_t;

    // One pending result before the divide
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } res_t;

    // ceil(2^16 / d) for every divisor that can occur; exact floor for sums below 2^15
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd0;
        endcase
        return m;
    endfunction

endpackage

FILE: src/box3_ctrl.sv
// Sequencer for the 3x3 box mean filter: input handshake, window results and row flush.
module box3_ctrl
    import box3_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_WA   = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_FR   = 3'd4;
    localparam logic [2:0] S_FD   = 3'd5;
    localparam logic [2:0] S_FO   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load = 1'b1;
                if (stat.emit_a)
                    state_next = S_WA;
                else if (stat.emit_b)
                    state_next = S_WB;
                else if (stat.flush)
                    state_next = S_FR;
                else
                    state_next = S_IDLE;
            end
            S_WA:
            begin
                if (s_ready)
                begin
                    cmd.issue_a = 1'b1;
                    if (stat.emit_b)
                        state_next = S_WB;
                    else if (stat.flush)
                        state_next = S_FR;
                    else
                        state_next = S_IDLE;
                end
            end
            S_WB:
            begin
                if (s_ready)
                begin
                    cmd.issue_b = 1'b1;
                    state_next  = stat.flush ? S_FR : S_IDLE;
                end
            end
            S_FR:
            begin
                if (!stat.fx_end)
                begin
                    cmd.fl_read = 1'b1;
                    state_next  = S_FD;
                end
                else
                begin
                    cmd.fl_phantom = 1'b1;
                    state_next     = S_FO;
                end
            end
            S_FD:
            begin
                cmd.fl_shift = 1'b1;
                state_next   = stat.fx_ready ? S_FO : S_FR;
            end
            S_FO:
            begin
                if (s_ready)
                begin
                    cmd.fl_issue = 1'b1;
                    state_next   = stat.fj_last ? S_IDLE : S_FR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: src/box3_dp.sv
// Datapath: line buffers, 3x3 window, frame position, flush sweep and neighbourhood sums.
module box3_dp
    import box3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [PIX_W-1:0]      pixel_in,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output res_t                  res,
    output logic                  issue
);

    // Line buffers
    logic [PIX_W-1:0] older_mem  [MAX_COLS];
    logic [PIX_W-1:0] recent_mem [MAX_COLS];
    logic [PIX_W-1:0] old_rd_reg;
    logic [PIX_W-1:0] rec_rd_reg;

    // Frame configuration and position
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic [ROW_W-1:0]      row_pos_reg;
    logic [COL_W-1:0]      col_pos_reg;
    logic [ROW_W-1:0]      cur_r_reg;
    logic [COL_W-1:0]      cur_c_reg;
    logic [PIX_W-1:0]      px_reg;

    // Window: win_reg[column][row], column 2 newest, row 2 current
    logic [PIX_W-1:0] win_reg [3][3];

    // Flush sweep
    logic [FX_W-1:0]   fx_reg;
    logic [COL_W-1:0]  fj_reg;
    logic [CSUM_W-1:0] cs_reg [3];

    logic [COL_W-1:0]      rd_addr;
    logic [ROW_W-1:0]      eff_r;
    logic [COL_W-1:0]      eff_c;
    logic                  c_last;
    logic                  r_last;
    logic [COLS_CFG_W-1:0] c_inc;
    logic [ROWS_CFG_W-1:0] r_inc;
    logic [CSUM_W-1:0]     cs_new;
    logic [FX_W-1:0]       fj_plus2;
    logic [FX_W-1:0]       fj_ext;

    // Window and flush sum terms
    logic [1:0]        k0;
    logic              r0;
    logic [1:0]        ncol;
    logic [1:0]        nrow;
    logic [SUM_W-1:0]  win_sum;
    logic [CNT_W-1:0]  win_cnt;
    logic              fl_left;
    logic              fl_right;
    logic [1:0]        fl_w;
    logic [SUM_W-1:0]  fl_sum;
    logic [CNT_W-1:0]  fl_cnt;

    assign eff_r  = ({1'b0, row_pos_reg} >= rows_reg) ? '0 : row_pos_reg;
    assign eff_c  = ({1'b0, col_pos_reg} >= cols_reg) ? '0 : col_pos_reg;
    assign c_last = ({1'b0, cur_c_reg} == cols_reg - 1'b1);
    assign r_last = ({1'b0, cur_r_reg} == rows_reg - 1'b1);
    assign c_inc  = {1'b0, cur_c_reg} + 1'b1;
    assign r_inc  = {1'b0, cur_r_reg} + 1'b1;
    assign fj_ext   = {1'b0, fj_reg};
    assign fj_plus2 = fj_ext + 2'd2;
    assign rd_addr  = cmd.accept ? eff_c : fx_reg[COL_W-1:0];
    assign cs_new   = {1'b0, rec_rd_reg} + ((cur_r_reg != '0) ? {1'b0, old_rd_reg} : '0);

    // Status
    assign stat.emit_a   = (cur_r_reg != '0) && (cur_c_reg != '0);
    assign stat.emit_b   = (cur_r_reg != '0) && c_last;
    assign stat.flush    = r_last && c_last;
    assign stat.fx_end   = (fx_reg >= cols_reg);
    assign stat.fx_ready = (fx_reg >= fj_plus2);
    assign stat.fj_last  = (fj_ext == cols_reg - 1'b1);

    // Line buffer read port, registered data
    always_ff @(posedge clk)
    begin
        if (cmd.accept || cmd.fl_read)
        begin
            old_rd_reg <= older_mem[rd_addr];
            rec_rd_reg <= recent_mem[rd_addr];
        end
    end

    // Line buffer write port: row r-1 moves to the older line, the new pixel into the recent one
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            older_mem[cur_c_reg]  <= rec_rd_reg;
            recent_mem[cur_c_reg] <= px_reg;
        end
    end

    // Input capture and window shift
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg    <= pixel_in;
            cur_r_reg <= eff_r;
            cur_c_reg <= eff_c;
        end
        if (cmd.load)
        begin
            for (int rr = 0; rr < 3; rr++)
            begin
                win_reg[0][rr] <= win_reg[1][rr];
                win_reg[1][rr] <= win_reg[2][rr];
            end
            win_reg[2][0] <= old_rd_reg;
            win_reg[2][1] <= rec_rd_reg;
            win_reg[2][2] <= px_reg;
        end
    end

    // Flush sliding column sums
    always_ff @(posedge clk)
    begin
        if (cmd.fl_shift || cmd.fl_phantom)
        begin
            cs_reg[0] <= cs_reg[1];
            cs_reg[1] <= cs_reg[2];
            cs_reg[2] <= cmd.fl_shift ? cs_new : '0;
        end
    end

    // Configuration, frame position and flush counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= ROWS_CFG_W'(1);
            cols_reg    <= COLS_CFG_W'(1);
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            fx_reg      <= '0;
            fj_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROWS)
                begin
                    if (cfg_data == '0)
                        rows_reg <= ROWS_CFG_W'(1);
                    else if (cfg_data > ROWS_CFG_W'(MAX_ROWS))
                        rows_reg <= ROWS_CFG_W'(MAX_ROWS);
                    else
                        rows_reg <= cfg_data;
                    row_pos_reg <= '0;
                    col_pos_reg <= '0;
                end
                else if (cfg_index == REG_COLS)
                begin
                    if (cfg_data[COLS_CFG_W-1:0] == '0)
                        cols_reg <= COLS_CFG_W'(1);
                    else if (cfg_data[COLS_CFG_W-1:0] > COLS_CFG_W'(MAX_COLS))
                        cols_reg <= COLS_CFG_W'(MAX_COLS);
                    else
                        cols_reg <= cfg_data[COLS_CFG_W-1:0];
                    row_pos_reg <= '0;
                    col_pos_reg <= '0;
                end
            end
            else if (cmd.load)
            begin
                if (c_inc >= cols_reg)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= (r_inc >= rows_reg) ? '0 : r_inc[ROW_W-1:0];
                end
                else
                begin
                    col_pos_reg <= c_inc[COL_W-1:0];
                    row_pos_reg <= cur_r_reg;
                end
            end

            if (cmd.load)
            begin
                fx_reg <= '0;
                fj_reg <= '0;
            end
            else
            begin
                if (cmd.fl_read || cmd.fl_phantom)
                    fx_reg <= fx_reg + 1'b1;
                if (cmd.fl_issue)
                    fj_reg <= fj_reg + 1'b1;
            end
        end
    end

    // Window neighbourhood sum: columns k0..2, rows r0..2
    always_comb
    begin
        k0      = cmd.issue_b ? ((cur_c_reg != '0) ? 2'd1 : 2'd2)
                              : ((cur_c_reg >= COL_W'(2)) ? 2'd0 : 2'd1);
        r0      = (cur_r_reg < ROW_W'(2));
        ncol    = 2'd3 - k0;
        nrow    = r0 ? 2'd2 : 2'd3;
        win_cnt = {2'b00, ncol} * {2'b00, nrow};
        win_sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (k >= int'(k0))
            begin
                win_sum = win_sum + SUM_W'(win_reg[k][1]) + SUM_W'(win_reg[k][2]);
                if (!r0)
                    win_sum = win_sum + SUM_W'(win_reg[k][0]);
            end
        end
    end

    // Final row neighbourhood from the sliding column sums
    always_comb
    begin
        fl_left  = (fj_reg != '0);
        fl_right = (fj_ext + 1'b1 < cols_reg);
        fl_w     = 2'd1 + {1'b0, fl_left} + {1'b0, fl_right};
        fl_cnt   = (cur_r_reg != '0) ? {1'b0, fl_w, 1'b0} : {2'b00, fl_w};
        fl_sum   = SUM_W'(cs_reg[1])
                 + (fl_left  ? SUM_W'(cs_reg[0]) : '0)
                 + (fl_right ? SUM_W'(cs_reg[2]) : '0);
    end

    // Result selection
    assign issue = cmd.issue_a || cmd.issue_b || cmd.fl_issue;

    always_comb
    begin
        if (cmd.fl_issue)
        begin
            res.sum  = fl_sum;
            res.cnt  = fl_cnt;
            res.row  = cur_r_reg;
            res.col  = fj_reg;
            res.last = stat.fj_last;
        end
        else
        begin
            res.sum  = win_sum;
            res.cnt  = win_cnt;
            res.row  = cur_r_reg - 1'b1;
            res.col  = cmd.issue_b ? cur_c_reg : cur_c_reg - 1'b1;
            res.last = cmd.issue_b ? !stat.flush : (!stat.emit_b && !stat.flush);
        end
    end

endmodule

FILE: src/box3_mean.sv
// Divide pipeline: sum register, reciprocal multiply and output register with handshake.
module box3_mean
    import box3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             issue,
    input  res_t             res,
    output logic             s_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] pixel_out,
    output logic [ROW_W-1:0] out_row,
    output logic [COL_W-1:0] out_col,
    output logic             last_of_run
);

    logic             sum_valid_reg;
    res_t             sum_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             last_reg;
    logic             o_load;
    logic [PROD_W-1:0] prod;

    assign o_load  = sum_valid_reg && (!out_valid_reg || out_ready);
    assign s_ready = !sum_valid_reg || o_load;
    assign prod    = PROD_W'(sum_reg.sum) * PROD_W'(recip(sum_reg.cnt));

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_ready)
                sum_valid_reg <= issue;
            if (o_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s_ready && issue)
            sum_reg <= res;
        if (o_load)
        begin
            pix_reg  <= prod[RECIP_SH +: PIX_W];
            row_reg  <= sum_reg.row;
            col_reg  <= sum_reg.col;
            last_reg <= sum_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_out   = pix_reg;
    assign out_row     = row_reg;
    assign out_col     = col_reg;
    assign last_of_run = last_reg;

endmodule

FILE: src/box_filter_3x3_edge_average_core.sv
// Top level of the 3x3 box mean filter with line buffers and edge-aware divisor.
// Pixels enter in raster order; each output is the floor of the mean of the in-frame
// pixels of its 3x3 neighbourhood, tagged with its row, column and a last-of-transaction
// flag. Frame size comes from image_rows (index 0) and image_cols (index 1); a write to
// either restarts the frame at (0,0). An input pixel produces at most two window results,
// each handed to the divider once it can take it; the last pixel of the frame also starts
// the final-row flush, in which the sequencer sweeps the line buffers through their single
// read port. Results leave through a two-register divide pipeline; a result waiting in it
// does not stop the next pixel from being taken, but one that the pipeline cannot yet take
// holds the sequencer, and with it the input.
module box_filter_3x3_edge_average_core
    import box3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      pixel_out,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_W-1:0]      out_col,
    output logic                  last_of_run,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;
    res_t  res;
    logic  issue;
    logic  s_ready;

    box3_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    box3_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pixel_in),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res),
        .issue     (issue)
    );

    box3_mean u_mean
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .res         (res),
        .s_ready     (s_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run)
    );

endmodule

FILE: dv/box_filter_3x3_edge_average_core_tb.sv
// Testbench for the 3x3 box mean filter: random frames checked against a built-in predictor.
`timescale 1ns / 1ps

module box_filter_3x3_edge_average_core_tb;
    import box3_pkg::*;

    // Indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int unsigned RANDOM_ITEMS  = 330;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned DRAIN_CYCLES  = 50;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned CYCLE_LIMIT   = 4000000;
    localparam int unsigned MAX_REPORTS   = 10;

    // One expected output pixel
    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } mean_rec_t;

    // Predicts the output pixels of the filter and checks the ones that come out
    class mean_scoreboard;
        logic [ROWS_CFG_W-1:0] rows_cfg;
        logic [COLS_CFG_W-1:0] cols_cfg;
        logic [PIX_W-1:0]      older_row [MAX_COLS];
        logic [PIX_W-1:0]      recent_row [MAX_COLS];
        logic [PIX_W-1:0]      win [3][3]; // [column: 2 newest][row: 2 current]
        int unsigned           row_at;
        int unsigned           col_at;
        mean_rec_t             expected_means [$];
        int unsigned           faults;

        function new();
            int i;
            rows_cfg = 1;
            cols_cfg = 1;
            faults   = 0;
            for (i = 0; i < MAX_COLS; i++)
            begin
                older_row[i]  = '0;
                recent_row[i] = '0;
            end
            restart();
        endfunction

        function void restart();
            int k;
            int j;
            row_at = 0;
            col_at = 0;
            for (k = 0; k < 3; k++)
                for (j = 0; j < 3; j++)
                    win[k][j] = '0;
        endfunction

        function int unsigned frame_rows();
            if (rows_cfg == 0)
                return 1;
            if (rows_cfg > MAX_ROWS)
                return MAX_ROWS;
            return rows_cfg;
        endfunction

        function int unsigned frame_cols();
            if (cols_cfg == 0)
                return 1;
            if (cols_cfg > MAX_COLS)
                return MAX_COLS;
            return cols_cfg;
        endfunction

        function int unsigned pending();
            return expected_means.size();
        endfunction

        // Register write; sizes restart the frame, other indexes do nothing
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ROWS:
                begin
                    rows_cfg = val[ROWS_CFG_W-1:0];
                    restart();
                end
                REG_COLS:
                begin
                    cols_cfg = val[COLS_CFG_W-1:0];
                    restart();
                end
                default: ;
            endcase
        endfunction

        function void push_mean(int unsigned sum, int unsigned cnt,
                                int unsigned row, int unsigned col);
            mean_rec_t rec;
            rec.mean = PIX_W'(sum / cnt);
            rec.row  = ROW_W'(row);
            rec.col  = COL_W'(col);
            rec.last = 1'b0;
            expected_means.push_back(rec);
        endfunction

        // Mean over window columns k0..2 and rows r0..2
        function void window_mean(int unsigned k0, int unsigned r0,
                                  int unsigned row, int unsigned col);
            int unsigned sum;
            int unsigned cnt;
            int unsigned k;
            int unsigned rr;
            sum = 0;
            cnt = 0;
            for (k = k0; k < 3; k++)
                for (rr = r0; rr < 3; rr++)
                begin
                    sum += win[k][rr];
                    cnt++;
                end
            push_mean(sum, cnt, row, col);
        endfunction

        // Accepted input pixel: shift the window, update lines, queue its outputs
        function void note_pixel(logic [PIX_W-1:0] px);
            int unsigned nrows;
            int unsigned ncols;
            int unsigned r;
            int unsigned c;
            int unsigned r0;
            int unsigned j;
            int unsigned lo;
            int unsigned hi;
            int unsigned x;
            int unsigned sum;
            int unsigned cnt;
            int unsigned first;
            int k;
            mean_rec_t rec;
            nrows = frame_rows();
            ncols = frame_cols();
            r = (row_at >= nrows) ? 0 : row_at;
            c = (col_at >= ncols) ? 0 : col_at;
            first = expected_means.size();

            for (k = 0; k < 3; k++)
            begin
                win[0][k] = win[1][k];
                win[1][k] = win[2][k];
            end
            win[2][0] = older_row[c];
            win[2][1] = recent_row[c];
            win[2][2] = px;
            older_row[c]  = recent_row[c];
            recent_row[c] = px;

            // window outputs for the row above
            if (r >= 1)
            begin
                r0 = (r >= 2) ? 0 : 1;
                if (c >= 1)
                    window_mean((c >= 2) ? 0 : 1, r0, r - 1, c - 1);
                if (c == ncols - 1)
                    window_mean((c >= 1) ? 1 : 2, r0, r - 1, c);
            end

            // last pixel of the frame flushes its own row
            if (r == nrows - 1 && c == ncols - 1)
            begin
                for (j = 0; j < ncols; j++)
                begin
                    lo  = (j >= 1) ? j - 1 : 0;
                    hi  = (j + 1 < ncols) ? j + 1 : j;
                    sum = 0;
                    cnt = 0;
                    for (x = lo; x <= hi; x++)
                    begin
                        sum += recent_row[x];
                        cnt++;
                        if (r >= 1)
                        begin
                            sum += older_row[x];
                            cnt++;
                        end
                    end
                    push_mean(sum, cnt, r, j);
                end
            end

            // advance raster position, wrapping at frame end
            if (c + 1 >= ncols)
            begin
                c = 0;
                r = (r + 1 >= nrows) ? 0 : r + 1;
            end
            else
                c = c + 1;
            row_at = r;
            col_at = c;

            if (expected_means.size() > first)
            begin
                rec = expected_means.pop_back();
                rec.last = 1'b1;
                expected_means.push_back(rec);
            end
        endfunction

        // Compare one output transaction with the oldest expected pixel
        function void check_mean(logic [PIX_W-1:0] pix, logic [ROW_W-1:0] row,
                                 logic [COL_W-1:0] col, logic last);
            mean_rec_t want;
            if (expected_means.size() == 0)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("unexpected result: mean %0d at (%0d,%0d) last %0b",
                             pix, row, col, last);
                return;
            end
            want = expected_means.pop_front();
            if (want.mean !== pix || want.row !== row || want.col !== col ||
                want.last !== last)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                begin
                    $display("result mismatch: expected mean %0d at (%0d,%0d) last %0b,",
                             want.mean, want.row, want.col, want.last);
                    $display("                 got mean %0d at (%0d,%0d) last %0b",
                             pix, row, col, last);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      pixel_out;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  last_of_run;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mean_scoreboard sb;
    bit             src_steady;
    bit             long_hold_req;

    box_filter_3x3_edge_average_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Pixel values weighted toward the extremes
    function automatic logic [PIX_W-1:0] rand_pixel();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return '0;
        if (roll < 4)
            return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // One input transaction, with an optional idle gap before it
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int unsigned gap;
        gap = src_steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_pixel(px);
    endtask

    // Drop valid right after the last accepted transaction of a burst
    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // All outputs in, then a margin for pixels that give no output
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        sb.set_reg(idx, CFG_DATA_W'(val));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Set the frame size, then send whole frames, sometimes cut short, within the budget
    task automatic run_phase(input int unsigned rows_val, input int unsigned cols_val,
                             input int unsigned budget, output int unsigned sent);
        int unsigned len;
        int unsigned n;
        wait_idle();
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(REG_ROWS, rows_val);
            write_reg(REG_COLS, cols_val);
        end
        else
        begin
            write_reg(REG_COLS, cols_val);
            write_reg(REG_ROWS, rows_val);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                      $urandom_range(0, 2047));
        len = sb.frame_rows() * sb.frame_cols();
        if (len > 160)
            sent = $urandom_range(1, 80);
        else
        begin
            sent = len * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0)
                sent = $urandom_range(1, sent);
        end
        if (sent > budget)
            sent = budget;
        src_steady = ($urandom_range(0, 3) == 0);
        for (n = 0; n < sent; n++)
            send_pixel(rand_pixel());
        end_burst();
    endtask

    // Output side: random stalls, calm stretches, one long hold on request
    initial
    begin : sink
        int unsigned hold;
        int unsigned calm;
        hold      = 0;
        calm      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (calm > 0)
                    calm--;
                else if ($urandom_range(0, 99) < 2)
                    calm = $urandom_range(40, 150);
                else if ($urandom_range(0, 2) == 0)
                    hold = pick_gap();
            end
        end
    end

    // Check every accepted output transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_mean(pixel_out, out_row, out_col, last_of_run);
    end

    // Run limit
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned random_items;
        int unsigned sent;
        int unsigned rows_val;
        int unsigned cols_val;
        int unsigned n;
        sb            = new();
        src_steady    = 1'b0;
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        pixel_in      = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ROWS;
        cfg_data      = '0;
        random_items  = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset size is a single pixel frame: divisor of one, wrap every pixel
        send_pixel(8'hFF);
        send_pixel(8'h00);
        end_burst();

        // zero sizes act as one
        wait_idle();
        write_reg(REG_ROWS, 0);
        write_reg(REG_COLS, 0);
        send_pixel(8'hAA);
        end_burst();

        // 3x3 frame: corners, edges and the full neighbourhood
        wait_idle();
        write_reg(REG_ROWS, 3);
        write_reg(REG_COLS, 3);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        end_burst();
        // writes past the register list leave the frame running
        wait_idle();
        write_reg(REG_SPARE_2, 11'h7FF);
        write_reg(REG_SPARE_3, 0);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h55);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        // start of the next frame, then cut off by a size write
        send_pixel(8'h0F);
        send_pixel(8'hF0);
        end_burst();

        // single row: divisors two and three
        wait_idle();
        write_reg(REG_ROWS, 1);
        write_reg(REG_COLS, 3);
        send_pixel(8'h55);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        end_burst();

        // single column
        wait_idle();
        write_reg(REG_ROWS, 2);
        write_reg(REG_COLS, 1);
        send_pixel(8'h80);
        send_pixel(8'h7F);
        end_burst();

        // oversized registers clamp to the largest frame
        wait_idle();
        write_reg(REG_ROWS, 2047);
        write_reg(REG_COLS, 63);
        send_pixel(8'h3C);
        send_pixel(8'hC3);
        send_pixel(8'hFF);
        end_burst();

        // wide frame with a long output hold so the block backs up into its input
        wait_idle();
        write_reg(REG_ROWS, 3);
        write_reg(REG_COLS, 32);
        src_steady    = 1'b1;
        long_hold_req = 1'b1;
        for (n = 0; n < 96; n++)
            send_pixel(rand_pixel());
        end_burst();
        random_items += 96;

        // random frame sizes, mostly small and complete
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       rows_val = 0;
                1:       rows_val = $urandom_range(1025, 2047);
                2, 3:    rows_val = $urandom_range(5, 40);
                default: rows_val = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 9))
                0:       cols_val = 0;
                1:       cols_val = $urandom_range(33, 63);
                2, 3:    cols_val = $urandom_range(9, 32);
                default: cols_val = $urandom_range(1, 8);
            endcase
            run_phase(rows_val, cols_val, RANDOM_ITEMS - random_items, sent);
            random_items += sent;
        end

        // drain and report
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.faults == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
src/box3_pkg.sv
src/box3_ctrl.sv
src/box3_dp.sv
src/box3_mean.sv
src/box_filter_3x3_edge_average_core.sv
dv/box_filter_3x3_edge_average_core_tb.sv
